[hw/rtl/sllt_pkg.sv]
package sllt_pkg;

  localparam int OP_W  = 3;
  localparam int KEY_W = 32;
  localparam int ST_W  = 3;
  localparam int CNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_FIND   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_LIST   = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE = 3'd0,
    ST_HIT  = 3'd1,
    ST_MISS = 3'd2,
    ST_FULL = 3'd3,
    ST_ITEM = 3'd4
  } status_e;

endpackage

[hw/rtl/sllt_item_if.sv]
interface sllt_item_if import sllt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [KEY_W-1:0] key_value;

  modport source (output valid, operation, key_value, input ready);
  modport sink (input valid, operation, key_value, output ready);
endinterface

[hw/rtl/sllt_result_if.sv]
interface sllt_result_if import sllt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [KEY_W-1:0] out_value;
  logic [CNT_W-1:0]        entry_count;
  logic                    last;

  modport source (output valid, status, out_value, entry_count, last, input ready);
  modport sink (input valid, status, out_value, entry_count, last, output ready);
endinterface

[hw/rtl/sorted_linked_list_table_top.sv]
// Channel   Port       Modport  Transaction
// input     item_i     sink     operation, key_value
// output    result_o   source   status, out_value, entry_count, last
//
// One item at a time; item_i.ready is high only while the sequencer is idle.
// Insert: scans from slot 0 for the lowest free slot k, walks the nodes through
// the node RAM (one read per cycle), writes the node, links it in, then outputs.
// Delete/find: accept, walk the nodes, then output; list: one result per entry.
// Clear and refused inserts go straight from accept to output.
// Reset empties the list at once; a stalled result holds the sequencer.
module sorted_linked_list_table_top import sllt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  sllt_item_if.sink      item_i,
  sllt_result_if.source  result_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(DEPTH + 1);
  localparam int MW = KEY_W + IW;
  localparam logic [IW-1:0] NULL_IDX = IW'(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_CHK  = 6'b000100,
    S_INS  = 6'b001000,
    S_LINK = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  logic [IW-1:0]           head_q, head_d;
  logic [IW-1:0]           count_q, count_d;
  logic [DEPTH-1:0]        valid_q, valid_d;
  logic                    more_q, more_d;
  op_e                     op_q, op_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [IW-1:0]           curr_q, curr_d;
  logic [IW-1:0]           prev_q, prev_d;
  logic signed [KEY_W-1:0] prev_val_q, prev_val_d;
  logic [IW-1:0]           steps_q, steps_d;
  logic [AW-1:0]           scan_q, scan_d;
  status_e                 st_q, st_d;
  logic signed [KEY_W-1:0] out_val_q, out_val_d;
  logic                    last_q, last_d;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [MW-1:0]           ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [MW-1:0]           ram_rdata;
  logic signed [KEY_W-1:0] rd_val;
  logic [IW-1:0]           rd_link;
  logic [IW-1:0]           rd_next;
  logic                    rd_fin;

  logic                    walk;
  logic [IW-1:0]           nxt_curr;
  logic [IW-1:0]           nxt_steps;
  logic                    item_ready;

  sllt_node_ram #(
    .DEPTH (DEPTH),
    .WIDTH (MW)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_val  = ram_rdata[MW-1:IW];
  assign rd_link = ram_rdata[IW-1:0];
  assign rd_next = (rd_link >= NULL_IDX) ? NULL_IDX : rd_link;
  assign rd_fin  = (rd_link >= NULL_IDX) || (steps_q + 1'b1 == NULL_IDX);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    valid_d    = valid_q;
    more_d     = more_q;
    op_d       = op_q;
    key_d      = key_q;
    curr_d     = curr_q;
    prev_d     = prev_q;
    prev_val_d = prev_val_q;
    steps_d    = steps_q;
    scan_d     = scan_q;
    st_d       = st_q;
    out_val_d  = out_val_q;
    last_d     = last_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    walk       = 1'b0;
    nxt_curr   = curr_q;
    nxt_steps  = steps_q;
    item_ready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_i.valid) begin
          op_d      = op_e'(item_i.operation);
          key_d     = item_i.key_value;
          out_val_d = item_i.key_value;
          st_d      = ST_DONE;
          last_d    = 1'b1;
          more_d    = 1'b0;
          prev_d    = NULL_IDX;
          state_d   = S_OUT;
          unique case (item_i.operation) inside
            OP_INSERT: begin
              if (count_q != NULL_IDX) begin
                scan_d  = '0;
                state_d = S_SCAN;
              end else begin
                st_d = ST_FULL;
              end
            end
            OP_DELETE, OP_FIND: begin
              walk      = 1'b1;
              nxt_curr  = head_q;
              nxt_steps = '0;
            end
            OP_CLEAR: begin
              valid_d = '0;
              head_d  = NULL_IDX;
              count_d = '0;
            end
            OP_LIST: begin
              if (head_q != NULL_IDX) begin
                walk      = 1'b1;
                nxt_curr  = head_q;
                nxt_steps = '0;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (!valid_q[scan_q]) begin
          walk      = 1'b1;
          nxt_curr  = head_q;
          nxt_steps = '0;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      S_CHK: begin
        unique case (op_q) inside
          OP_INSERT: begin
            if (rd_val < key_q) begin
              prev_d     = curr_q;
              prev_val_d = rd_val;
              walk       = 1'b1;
              nxt_curr   = rd_link;
              nxt_steps  = steps_q + 1'b1;
            end else begin
              state_d = S_INS;
            end
          end
          OP_DELETE, OP_FIND: begin
            if (rd_val == key_q) begin
              st_d      = ST_HIT;
              out_val_d = key_q;
              last_d    = 1'b1;
              more_d    = 1'b0;
              state_d   = S_OUT;
              if (op_q == OP_DELETE) begin
                if (prev_q == NULL_IDX) begin
                  head_d = rd_next;
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = prev_q[AW-1:0];
                  ram_wdata = {prev_val_q, rd_next};
                end
                valid_d[curr_q[AW-1:0]] = 1'b0;
                if (count_q != '0) begin
                  count_d = count_q - 1'b1;
                end
              end
            end else begin
              prev_d     = curr_q;
              prev_val_d = rd_val;
              walk       = 1'b1;
              nxt_curr   = rd_link;
              nxt_steps  = steps_q + 1'b1;
            end
          end
          OP_LIST: begin
            st_d      = ST_ITEM;
            out_val_d = rd_val;
            last_d    = rd_fin;
            more_d    = !rd_fin;
            curr_d    = rd_link;
            steps_d   = steps_q + 1'b1;
            state_d   = S_OUT;
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = scan_q;
        ram_wdata = {key_q, curr_q};
        state_d   = S_LINK;
      end

      S_LINK: begin
        if (prev_q == NULL_IDX) begin
          head_d = IW'(scan_q);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = prev_q[AW-1:0];
          ram_wdata = {prev_val_q, IW'(scan_q)};
        end
        valid_d[scan_q] = 1'b1;
        count_d         = count_q + 1'b1;
        st_d            = ST_DONE;
        out_val_d       = key_q;
        last_d          = 1'b1;
        more_d          = 1'b0;
        state_d         = S_OUT;
      end

      S_OUT: begin
        if (result_o.ready) begin
          if (more_q) begin
            walk      = 1'b1;
            nxt_curr  = curr_q;
            nxt_steps = steps_q;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (walk) begin
      steps_d = nxt_steps;
      if ((nxt_curr >= NULL_IDX) || (nxt_steps == NULL_IDX)) begin
        curr_d = (nxt_curr >= NULL_IDX) ? NULL_IDX : nxt_curr;
        unique case (op_d) inside
          OP_INSERT: state_d = S_INS;
          OP_DELETE, OP_FIND: begin
            st_d      = ST_MISS;
            out_val_d = key_d;
            last_d    = 1'b1;
            more_d    = 1'b0;
            state_d   = S_OUT;
          end
          default: state_d = S_IDLE;
        endcase
      end else begin
        ram_re    = 1'b1;
        ram_raddr = nxt_curr[AW-1:0];
        curr_d    = nxt_curr;
        state_d   = S_CHK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= NULL_IDX;
      count_q <= '0;
      valid_q <= '0;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      valid_q <= valid_d;
      more_q  <= more_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    curr_q     <= curr_d;
    prev_q     <= prev_d;
    prev_val_q <= prev_val_d;
    steps_q    <= steps_d;
    scan_q     <= scan_d;
    st_q       <= st_d;
    out_val_q  <= out_val_d;
    last_q     <= last_d;
  end

  assign item_i.ready         = item_ready;
  assign result_o.valid       = (state_q == S_OUT);
  assign result_o.status      = st_q;
  assign result_o.out_value   = out_val_q;
  assign result_o.entry_count = CNT_W'(count_q);
  assign result_o.last        = last_q;

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count disagrees with valid bitmap");

  a_head_null_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == (head_q == NULL_IDX))
    else $error("head pointer disagrees with entry count");

  a_read_then_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (state_q == S_CHK))
    else $error("node read not followed by check");

  a_scan_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (count_q != NULL_IDX))
    else $error("free slot scan on a full table");
`endif

endmodule

[hw/rtl/sllt_node_ram.sv]
module sllt_node_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 37
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
